// ----- design/lgge_pkg.sv -----
// Package for the life grid engine: sizes, opcodes, beat types, row helpers.
package lgge_pkg;

    localparam int GRID_SIZE = 32;
    localparam int ROW_W     = GRID_SIZE;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int CNT_W     = $clog2(GRID_SIZE + 1);
    localparam int MID       = GRID_SIZE / 2;
    localparam int COORD_W   = 5;

    typedef enum logic [1:0] {
        OP_TOGGLE  = 2'd0,
        OP_WRITE   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               write_value;
    } t_in_beat;

    typedef struct packed {
        logic cell_value;
        logic guard_alive;
    } t_out_beat;

    // Contents of a row straight after reset
    function automatic logic [ROW_W-1:0] reset_row(input logic [IDX_W-1:0] idx);
        logic [ROW_W-1:0] res;
        res = '0;
        if (idx == IDX_W'(MID) || idx == IDX_W'(MID + 1)) begin
            res = ROW_W'(3) << MID;
        end
        return res;
    endfunction

    // B3/S23 for one row; cells beyond the edges are dead
    function automatic logic [ROW_W-1:0] next_row(
        input logic [ROW_W-1:0] above,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] below
    );
        logic [ROW_W-1:0] res;
        logic [ROW_W-1:0] al, ar, ml, mr, bl, br;
        logic [3:0]       n;
        res = '0;
        al  = above << 1;
        ar  = above >> 1;
        ml  = mid << 1;
        mr  = mid >> 1;
        bl  = below << 1;
        br  = below >> 1;
        for (int c = 0; c < ROW_W; c++) begin
            n = 4'(al[c]) + 4'(above[c]) + 4'(ar[c]) + 4'(ml[c]) + 4'(mr[c])
              + 4'(bl[c]) + 4'(below[c]) + 4'(br[c]);
            res[c] = mid[c] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
        end
        return res;
    endfunction

endpackage

// ----- design/life_grid_generation_engine.sv -----
// Life grid engine: cell access and B3/S23 generation steps on a row memory.
// Toggle, write and read: registered row read, then S_RMW writes back and registers the result.
// Generation: one row read, windowed and written back per cycle; the result is
// registered with the last step, and the engine then returns to idle.
// One beat at a time; a new beat is taken while a result waits, a stalled result holds the last step.
// Synchronous active-low reset restores the dead grid with a live centre 2x2.
module life_grid_generation_engine
    import lgge_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_ADV
    } t_state;

    // Row store; rows not yet written read as their reset contents
    logic [ROW_W-1:0] r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_valid;

    // Registered read port
    logic [ROW_W-1:0] r_rd_row;
    logic             r_rd_ok;
    logic [IDX_W-1:0] r_rd_addr;
    logic [IDX_W-1:0] rd_addr;

    // Write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_row, n_row;
    logic             r_wv, n_wv;
    logic             r_in_grid, n_in_grid;
    logic [CNT_W-1:0] r_k, n_k;           // rows arrived in the window
    logic [ROW_W-1:0] r_prev, n_prev;     // old row k-2
    logic [ROW_W-1:0] r_cur, n_cur;       // old row k-1
    logic             r_cell, n_cell;     // new value of addressed cell
    logic [3:0]       r_guard, n_guard;   // mirror of the four centre cells
    logic             r_out_vld, n_out_vld;
    t_out_beat        r_out, n_out;

    logic             in_accept;
    logic             out_free;
    logic [ROW_W-1:0] eff_row;
    logic [ROW_W-1:0] adv_in;
    logic [ROW_W-1:0] life;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] mod_row;
    logic [CNT_W-1:0] k_m1;
    logic [CNT_W-1:0] k_p1;
    logic             last_step;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_col     = r_col;
        n_row     = r_row;
        n_wv      = r_wv;
        n_in_grid = r_in_grid;
        n_k       = r_k;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_cell    = r_cell;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        rd_addr   = r_rd_addr;
        wr_en     = 1'b0;
        wr_addr   = r_row;
        wr_data   = '0;

        out_free  = !r_out_vld || !i_out_stall;
        eff_row   = r_rd_ok ? r_rd_row : reset_row(r_rd_addr);
        last_step = (r_k == CNT_W'(GRID_SIZE));
        adv_in    = last_step ? '0 : eff_row;
        life      = next_row(r_prev, r_cur, adv_in);
        k_m1      = r_k - 1'b1;
        k_p1      = r_k + 1'b1;
        mask      = ROW_W'(1) << r_col;
        mod_row   = eff_row;
        if (r_op == OP_TOGGLE) begin
            mod_row = eff_row ^ mask;
        end else if (r_op == OP_WRITE) begin
            mod_row = (eff_row & ~mask) | (r_wv ? mask : '0);
        end

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op      = i_in.op;
                    n_col     = i_in.col[IDX_W-1:0];
                    n_row     = i_in.row[IDX_W-1:0];
                    n_wv      = i_in.write_value;
                    n_in_grid = (32'(i_in.col) < GRID_SIZE) && (32'(i_in.row) < GRID_SIZE);
                    if (i_in.op == OP_ADVANCE) begin
                        rd_addr = '0;
                        n_k     = '0;
                        n_prev  = '0;
                        n_cur   = '0;
                        n_cell  = 1'b0;
                        n_state = S_ADV;
                    end else begin
                        rd_addr = i_in.row[IDX_W-1:0];
                        n_state = S_RMW;
                    end
                end
            end
            S_RMW: begin
                if (out_free) begin
                    wr_en     = r_in_grid && (r_op == OP_TOGGLE || r_op == OP_WRITE);
                    wr_addr   = r_row;
                    wr_data   = mod_row;
                    n_cell    = r_in_grid && mod_row[r_col];
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_ADV: begin
                if (!last_step || out_free) begin
                    n_prev = r_cur;
                    n_cur  = adv_in;
                    n_k    = k_p1;
                    if (r_k != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = k_m1[IDX_W-1:0];
                        wr_data = life;
                        if (k_m1[IDX_W-1:0] == r_row) begin
                            n_cell = r_in_grid && life[r_col];
                        end
                    end
                    if (k_p1 < CNT_W'(GRID_SIZE)) begin
                        rd_addr = k_p1[IDX_W-1:0];
                    end
                    if (last_step) begin
                        n_out_vld = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Keep the centre mirror in step with the write port
        n_guard = r_guard;
        if (wr_en && wr_addr == IDX_W'(MID)) begin
            n_guard[1:0] = wr_data[MID+1:MID];
        end
        if (wr_en && wr_addr == IDX_W'(MID + 1)) begin
            n_guard[3:2] = wr_data[MID+1:MID];
        end

        if (n_state == S_IDLE && r_state != S_IDLE) begin
            n_out.cell_value  = n_cell;
            n_out.guard_alive = &n_guard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_guard   <= 4'b1111;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_guard   <= n_guard;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
        r_op      <= n_op;
        r_col     <= n_col;
        r_row     <= n_row;
        r_wv      <= n_wv;
        r_in_grid <= n_in_grid;
        r_k       <= n_k;
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        r_cell    <= n_cell;
        r_out     <= n_out;
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_row  <= r_mem[rd_addr];
        r_rd_ok   <= r_valid[rd_addr];
        r_rd_addr <= rd_addr;
    end

endmodule
